[sv/lsm_pkg.sv]
// Shared types and constants for the bounded stack with running maximum.
package lsm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = 7;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE     = 1'b0,
        S_POP_LOAD = 1'b1
    } fsm_state_t;

    typedef struct packed {
        cmd_t                     command;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        status_t                  status;
        logic [DEPTH_W-1:0]       depth;
        logic signed [WORD_W-1:0] max_value;
    } rsp_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic signed [WORD_W-1:0] run_max;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic pop_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic pop_multi;
    } dp_status_t;

endpackage

[sv/lifo_stack_with_max.sv]
// Top level of the bounded stack of signed words with running maximum.
// Push, peek and clear each write their result into the output register straight from
// the accepted beat, as does a pop or peek on an empty stack. A pop that removes an entry
// also passes through the S_POP_LOAD state, because the entry that becomes the new top
// sits in the entry memory and arrives through its registered read port; no request beat
// is taken in that state. The top entry and its running maximum are held in registers,
// so the largest stored word is always at hand. Memory contents are not cleared after
// reset and no clearing pass is needed: only entries below the current depth are ever
// used. A new request beat is taken while the previous result waits, as long as the
// output register is free or being drained.
module lifo_stack_with_max (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lsm_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lsm_pkg::rsp_t m_data
);

    lsm_pkg::ctrl_cmd_t  cmd;
    lsm_pkg::dp_status_t status;

    lsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lsm_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

[sv/lsm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/lsm_ctrl.sv]
// Controller state machine that sequences requests and the S_POP_LOAD step of a pop.
module lsm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lsm_pkg::dp_status_t   status,
    output lsm_pkg::ctrl_cmd_t    cmd
);

    lsm_pkg::fsm_state_t state_reg;
    lsm_pkg::fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsm_pkg::S_IDLE: begin
                if (cmd.accept && status.pop_multi) begin
                    state_next = lsm_pkg::S_POP_LOAD;
                end
            end
            lsm_pkg::S_POP_LOAD: begin
                state_next = lsm_pkg::S_IDLE;
            end
            default: begin
                state_next = lsm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.pop_finish = 1'b0;
        unique case (state_reg)
            lsm_pkg::S_IDLE: begin
                s_ready = !status.out_busy;
            end
            lsm_pkg::S_POP_LOAD: begin
                cmd.pop_finish = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.accept = s_valid && s_ready;
    end

endmodule

[sv/lsm_dp.sv]
// Datapath: entry count, cached top entry, entry memory and result register.
module lsm_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lsm_pkg::ctrl_cmd_t    cmd,
    output lsm_pkg::dp_status_t   status,
    input  lsm_pkg::req_t         s_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output lsm_pkg::rsp_t         m_data
);

    logic [lsm_pkg::COUNT_W-1:0]       count_reg;
    logic [lsm_pkg::COUNT_W-1:0]       count_next;
    logic signed [lsm_pkg::WORD_W-1:0] top_word_reg;
    logic signed [lsm_pkg::WORD_W-1:0] top_word_next;
    logic signed [lsm_pkg::WORD_W-1:0] top_max_reg;
    logic signed [lsm_pkg::WORD_W-1:0] top_max_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    lsm_pkg::rsp_t                     m_data_reg;
    lsm_pkg::rsp_t                     m_data_next;

    lsm_pkg::rsp_t                     res;
    logic                              empty;
    logic                              full;
    logic                              push_en;
    logic                              pop_multi;
    logic                              pop_one;
    logic signed [lsm_pkg::WORD_W-1:0] new_max;
    logic                              wr_en;
    logic [lsm_pkg::ADDR_W-1:0]        wr_addr;
    logic [lsm_pkg::ADDR_W-1:0]        rd_addr;
    lsm_pkg::entry_t                   wr_entry;
    lsm_pkg::entry_t                   rd_entry;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == lsm_pkg::COUNT_W'(lsm_pkg::STACK_DEPTH));

    always_comb begin
        res           = '0;
        res.status    = lsm_pkg::ST_OK;
        res.depth     = lsm_pkg::DEPTH_W'(count_reg);
        res.max_value = empty ? '0 : top_max_reg;
        push_en       = 1'b0;
        pop_multi     = 1'b0;
        pop_one       = 1'b0;
        new_max       = s_data.push_value;
        if (!empty && (top_max_reg > s_data.push_value)) begin
            new_max = top_max_reg;
        end
        unique case (s_data.command) inside
            lsm_pkg::CMD_PUSH: begin
                if (full) begin
                    res.status = lsm_pkg::ST_FULL;
                end else begin
                    push_en       = 1'b1;
                    res.max_value = new_max;
                    res.depth     = lsm_pkg::DEPTH_W'(count_reg + 1'b1);
                end
            end
            lsm_pkg::CMD_POP, lsm_pkg::CMD_PEEK: begin
                if (empty) begin
                    res.status = lsm_pkg::ST_EMPTY;
                end else begin
                    res.top_value = top_word_reg;
                    if (s_data.command == lsm_pkg::CMD_POP) begin
                        pop_one   = 1'b1;
                        pop_multi = 1'b1;
                        res.depth = lsm_pkg::DEPTH_W'(count_reg - 1'b1);
                    end
                end
            end
            lsm_pkg::CMD_CLEAR: begin
                res.depth     = '0;
                res.max_value = '0;
            end
            default: begin
                res.status = lsm_pkg::ST_OK;
            end
        endcase
    end

    assign status.out_busy  = m_valid_reg && !m_ready;
    assign status.pop_multi = pop_multi;

    // The entry below the top lives in memory; its address is read every cycle.
    assign wr_en            = cmd.accept && push_en && !empty;
    assign wr_addr          = lsm_pkg::ADDR_W'(count_reg - 1'b1);
    assign rd_addr          = lsm_pkg::ADDR_W'(count_reg - lsm_pkg::COUNT_W'(2));
    assign wr_entry.word    = top_word_reg;
    assign wr_entry.run_max = top_max_reg;

    lsm_ram #(
        .WIDTH ($bits(lsm_pkg::entry_t)),
        .DEPTH (lsm_pkg::STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    always_comb begin
        count_next    = count_reg;
        top_word_next = top_word_reg;
        top_max_next  = top_max_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        if (cmd.accept) begin
            m_data_next = res;
            if (!pop_multi) begin
                m_valid_next = 1'b1;
            end
            if (push_en) begin
                count_next    = count_reg + 1'b1;
                top_word_next = s_data.push_value;
                top_max_next  = new_max;
            end else if (pop_one) begin
                count_next = count_reg - 1'b1;
            end else if (s_data.command == lsm_pkg::CMD_CLEAR) begin
                count_next = '0;
            end
        end
        if (cmd.pop_finish) begin
            top_word_next         = rd_entry.word;
            top_max_next          = rd_entry.run_max;
            m_data_next.max_value = empty ? '0 : rd_entry.run_max;
            m_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        top_word_reg <= top_word_next;
        top_max_reg  <= top_max_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sv/lsm_chk.sv]
// Port-level checker for the stack, bound to the top level.
module lsm_chk (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input lsm_pkg::rsp_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid directly after reset");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.depth <= lsm_pkg::DEPTH_W'(lsm_pkg::STACK_DEPTH)))
        else $error("reported depth exceeds the stack size");

    a_empty_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == lsm_pkg::ST_EMPTY)) |->
        ((m_data.depth == '0) && (m_data.top_value == '0) && (m_data.max_value == '0)))
        else $error("empty status with non-zero fields");

    a_full_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == lsm_pkg::ST_FULL)) |->
        (m_data.depth == lsm_pkg::DEPTH_W'(lsm_pkg::STACK_DEPTH)))
        else $error("full status while not at full depth");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed");

endmodule

bind lifo_stack_with_max lsm_chk u_lsm_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/tb_lifo_stack_with_max.sv]
// Self-checking testbench for the bounded signed-word stack with running maximum.
module tb_lifo_stack_with_max;
    timeunit 1ns;
    timeprecision 1ps;

    import lsm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int CALM_FROM   = 800;
    localparam int CALM_TO     = 1400;
    localparam int RANDOM_REQS = 1150;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    req_t pending_req_q[$];
    rsp_t expected_rsp_q[$];

    logic signed [WORD_W-1:0] stored_word [STACK_DEPTH];
    logic signed [WORD_W-1:0] stored_peak [STACK_DEPTH];
    int held_count   = 0;
    int error_count  = 0;
    int cycle_count  = 0;
    int quiet_cycles = 0;
    logic calm;

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    lifo_stack_with_max uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic rsp_t apply_stack_request(req_t req);
        rsp_t rsp;
        logic signed [WORD_W-1:0] peak;
        rsp = '0;
        rsp.status = ST_OK;
        case (req.command)
            CMD_PUSH: begin
                if (held_count >= STACK_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    peak = req.push_value;
                    if (held_count > 0 && stored_peak[held_count-1] > peak) begin
                        peak = stored_peak[held_count-1];
                    end
                    stored_word[held_count] = req.push_value;
                    stored_peak[held_count] = peak;
                    held_count++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (held_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.top_value = stored_word[held_count-1];
                    if (req.command == CMD_POP) begin
                        held_count--;
                    end
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        rsp.depth = DEPTH_W'(held_count);
        if (held_count > 0) begin
            rsp.max_value = stored_peak[held_count-1];
        end
        return rsp;
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return $signed(WORD_W'($urandom_range(0, 16))) - 8;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shffff_ffff;
                endcase
            end
        endcase
    endfunction

    task automatic queue_request(cmd_t cmd, logic signed [WORD_W-1:0] value);
        req_t req;
        req.command    = cmd;
        req.push_value = value;
        pending_req_q.push_back(req);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Driver: a new beat is offered only once the current one has been taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsp_q.push_back(apply_stack_request(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_req_q.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_req_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 32);
            if (m_valid && m_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result beat %p", $time, m_data);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (m_data.top_value !== want.top_value) begin
                        error_count++;
                        $display("%0t: top_value expected %0d actual %0d",
                                 $time, want.top_value, m_data.top_value);
                    end
                    if (m_data.status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %s actual %0d",
                                 $time, want.status.name(), m_data.status);
                    end
                    if (m_data.depth !== want.depth) begin
                        error_count++;
                        $display("%0t: depth expected %0d actual %0d",
                                 $time, want.depth, m_data.depth);
                    end
                    if (m_data.max_value !== want.max_value) begin
                        error_count++;
                        $display("%0t: max_value expected %0d actual %0d",
                                 $time, want.max_value, m_data.max_value);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (pending_req_q.size() == 0 && !s_valid && expected_rsp_q.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("lifo_stack_with_max test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int issued;
        int run_len;
        int push_pct;
        int pop_pct;
        int peek_pct;
        int roll;
        cmd_t cmd;

        queue_request(CMD_PEEK, 32'sh1234_5678);
        queue_request(CMD_POP, 32'sh0);
        queue_request(CMD_CLEAR, 32'shffff_ffff);
        queue_request(CMD_PUSH, 32'sh7fff_ffff);
        queue_request(CMD_PEEK, 32'sh0);
        queue_request(CMD_PUSH, 32'sh8000_0000);
        queue_request(CMD_PUSH, 32'shffff_ffff);
        queue_request(CMD_PUSH, 32'sh0);
        queue_request(CMD_POP, 32'sh5555_5555);
        queue_request(CMD_POP, 32'shaaaa_aaaa);
        queue_request(CMD_POP, 32'sh0);
        queue_request(CMD_POP, 32'sh0);
        queue_request(CMD_POP, 32'sh0);
        queue_request(CMD_PUSH, 32'sh8000_0000);
        queue_request(CMD_PUSH, 32'sh8000_0000);
        queue_request(CMD_PUSH, 32'sh5);
        queue_request(CMD_CLEAR, 32'sh0);
        queue_request(CMD_PEEK, 32'sh0);
        queue_request(CMD_PUSH, -32'sd3);
        queue_request(CMD_PUSH, -32'sd7);
        queue_request(CMD_PUSH, -32'sd2);
        queue_request(CMD_POP, 32'sh0);
        queue_request(CMD_POP, 32'sh0);
        queue_request(CMD_CLEAR, 32'sh0);

        // The random part opens by filling the stack and pushing past the top.
        for (issued = 0; issued < STACK_DEPTH + 6; issued++) begin
            queue_request(CMD_PUSH, pick_word());
        end
        while (issued < RANDOM_REQS) begin
            run_len = $urandom_range(20, 150);
            if (run_len > RANDOM_REQS - issued) begin
                run_len = RANDOM_REQS - issued;
            end
            case ($urandom_range(0, 2))
                0: begin push_pct = 85; pop_pct = 6;  peek_pct = 8;  end
                1: begin push_pct = 8;  pop_pct = 70; peek_pct = 20; end
                default: begin push_pct = 40; pop_pct = 28; peek_pct = 26; end
            endcase
            repeat (run_len) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct) begin
                    cmd = CMD_PUSH;
                end else if (roll < push_pct + pop_pct) begin
                    cmd = CMD_POP;
                end else if (roll < push_pct + pop_pct + peek_pct) begin
                    cmd = CMD_PEEK;
                end else begin
                    cmd = CMD_CLEAR;
                end
                queue_request(cmd, pick_word());
                issued++;
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_req_q.size() != 0 || s_valid || expected_rsp_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("lifo_stack_with_max test passed");
        end else begin
            $display("lifo_stack_with_max test failed");
        end
        $finish;
    end

endmodule
